// File: rtl/hsr_pkg.sv
// Package for the HSV hue shift recolor block: payload structs, constants,
// register indexes and the divider step function. No dependencies.
`default_nettype none
package hsr_pkg;

  localparam int NUM_STAGES = 14;

  localparam logic [14:0] HUE_TURN   = 15'd23040;
  localparam logic [14:0] HUE_SECTOR = 15'd3840;
  localparam logic [15:0] HUE_TWO_TURNS = 16'd46080;

  localparam logic [1:0] REG_HUE_OFFSET = 2'd0;
  localparam logic [1:0] REG_SAT_GAIN   = 2'd1;
  localparam logic [1:0] REG_VAL_GAIN   = 2'd2;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_pix_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_pix_t;

  // One lane of the restoring divider: partial remainder, a shift word that
  // holds the numerator bits still to come and collects quotient bits, and
  // the divisor.
  typedef struct packed {
    logic [7:0]  rem;
    logic [15:0] sh;
    logic [7:0]  den;
  } div_lane_t;

  function automatic div_lane_t div_step4(input div_lane_t lane);
    div_lane_t  l;
    logic [8:0] t;
    l = lane;
    for (int k = 0; k < 4; k++) begin
      t = {l.rem, l.sh[15]};
      l.sh = {l.sh[14:0], 1'b0};
      if (t >= {1'b0, l.den}) begin
        t = t - {1'b0, l.den};
        l.sh[0] = 1'b1;
      end
      l.rem = t[7:0];
    end
    return l;
  endfunction

endpackage
`default_nettype wire

// File: rtl/hsr_div_stage.sv
// One registered stage of the two-lane restoring divider, four quotient bits
// per lane. Depends on hsr_pkg.
`default_nettype none
module hsr_div_stage (
  input  wire                 clk,
  input  wire                 en,
  input  hsr_pkg::div_lane_t  hue_in,
  input  hsr_pkg::div_lane_t  sat_in,
  output hsr_pkg::div_lane_t  hue_out,
  output hsr_pkg::div_lane_t  sat_out
);
  import hsr_pkg::*;

  div_lane_t hue_r, sat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r <= div_step4(hue_in);
      sat_r <= div_step4(sat_in);
    end
  end

  assign hue_out = hue_r;
  assign sat_out = sat_r;
endmodule
`default_nettype wire

// File: rtl/hsv_hue_shift_recolor_top.sv
// Top level of the HSV hue shift recolor block: pipeline, APB register file.
// Depends on hsr_pkg and hsr_div_stage.
//
// Usage: each input word is one 8-bit RGB pixel on in_data, moved when
// in_valid is high and in_stall is low. The pixel is taken to HSV, its hue
// is rotated by hue_offset (1/64 degree, wrapped into one turn), saturation
// and value are scaled by Q0.16 gains, and the pixel is taken back to RGB.
// Each result word appears on out_data with out_valid and leaves when
// out_stall is low. One result word for every input word, in order.
// Throughput is one pixel per cycle while the receiver does not stall,
// set by a 14-stage pipeline whose longest parts are the four divider
// stages (hue and saturation quotients, four bits per stage) and the
// gain and chroma multipliers.
// Each stage moves forward when it is empty or the stage after it moves,
// so empty slots are squeezed out and the block keeps taking pixels while
// a finished result waits; in_stall rises only when every stage is full
// and the receiver stalls. A stalled result holds steady.
// Reset empties the pipeline and sets hue_offset to 0 and both gains to
// 65535. Registers sit at byte addresses 0, 4 and 8 of the APB port. The
// user must write them only while the pipeline is empty: no check enforces it.
`default_nettype none
module hsv_hue_shift_recolor_top (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  hsr_pkg::in_pix_t  in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output hsr_pkg::out_pix_t out_data,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [3:0]        paddr,
  input  wire  [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import hsr_pkg::*;

  localparam int N = NUM_STAGES;

  localparam logic [1:0] SAT_DIV  = 2'd0;
  localparam logic [1:0] SAT_ZERO = 2'd1;
  localparam logic [1:0] SAT_FULL = 2'd2;

  // Configuration registers.
  logic [14:0] hue_offset_r;
  logic [15:0] sat_gain_r;
  logic [15:0] val_gain_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_offset_r <= 15'd0;
      sat_gain_r   <= 16'hFFFF;
      val_gain_r   <= 16'hFFFF;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_HUE_OFFSET: hue_offset_r <= pwdata[14:0];
        REG_SAT_GAIN:   sat_gain_r   <= pwdata[15:0];
        REG_VAL_GAIN:   val_gain_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HUE_OFFSET: prdata = {17'd0, hue_offset_r};
      REG_SAT_GAIN:   prdata = {16'd0, sat_gain_r};
      REG_VAL_GAIN:   prdata = {16'd0, val_gain_r};
      default:        prdata = 32'd0;
    endcase
  end

  // Valid bits and stage enables. A stage loads when any stage from it to the
  // output is empty or the receiver takes the word.
  logic [N:1] v_r;
  logic [N:1] en;

  always_comb begin
    logic full;
    for (int i = 1; i <= N; i++) begin
      full = out_stall;
      for (int j = i; j <= N; j++) full = full & v_r[j];
      en[i] = !full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_valid;
      for (int i = 2; i <= N; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = v_r[N];

  // Stage 1: input pixel.
  logic [7:0] s1_r_r, s1_g_r, s1_b_r;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_r_r <= in_data.in_red;
      s1_g_r <= in_data.in_green;
      s1_b_r <= in_data.in_blue;
    end
  end

  // Stage 2: max, min, delta, hue sector base and divider set-up.
  typedef struct packed {
    logic [7:0]  mx;
    logic [14:0] base;
    logic        plus;
    logic [1:0]  smode;
  } side_t;

  side_t     side_r [2:6];
  div_lane_t hue_lane [0:4];
  div_lane_t sat_lane [0:4];

  side_t     s2_side;
  div_lane_t s2_hue, s2_sat;

  always_comb begin
    logic [7:0]  mx, mn, d, a;
    logic [11:0] a15;
    mx = s1_r_r;
    mn = s1_r_r;
    if (s1_g_r > mx) mx = s1_g_r;
    if (s1_b_r > mx) mx = s1_b_r;
    if (s1_g_r < mn) mn = s1_g_r;
    if (s1_b_r < mn) mn = s1_b_r;
    d = mx - mn;
    s2_side.mx = mx;
    if (d == 8'd0) begin
      s2_side.base = 15'd0;
      s2_side.plus = 1'b1;
      a = 8'd0;
    end else if (mx == s1_r_r) begin
      if (s1_g_r >= s1_b_r) begin
        s2_side.base = 15'd0;
        s2_side.plus = 1'b1;
        a = s1_g_r - s1_b_r;
      end else begin
        s2_side.base = HUE_TURN;
        s2_side.plus = 1'b0;
        a = s1_b_r - s1_g_r;
      end
    end else if (mx == s1_g_r) begin
      s2_side.base = 15'(2 * HUE_SECTOR);
      s2_side.plus = (s1_b_r >= s1_r_r);
      a = (s1_b_r >= s1_r_r) ? s1_b_r - s1_r_r : s1_r_r - s1_b_r;
    end else begin
      s2_side.base = 15'(4 * HUE_SECTOR);
      s2_side.plus = (s1_r_r >= s1_g_r);
      a = (s1_r_r >= s1_g_r) ? s1_r_r - s1_g_r : s1_g_r - s1_r_r;
    end
    // Hue numerator is 3840 * a, that is 15 * a shifted up by eight.
    a15 = {a, 4'd0} - {4'd0, a};
    s2_hue.rem = {4'd0, a15[11:8]};
    s2_hue.sh  = {a15[7:0], 8'd0};
    s2_hue.den = (d == 8'd0) ? 8'd1 : d;
    if (mx == 8'd0) begin
      s2_side.smode = SAT_ZERO;
      s2_sat.rem = 8'd0;
      s2_sat.den = 8'd1;
    end else if (d == mx) begin
      s2_side.smode = SAT_FULL;
      s2_sat.rem = 8'd0;
      s2_sat.den = 8'd1;
    end else begin
      s2_side.smode = SAT_DIV;
      s2_sat.rem = d;
      s2_sat.den = mx;
    end
    s2_sat.sh = 16'd0;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      side_r[2]   <= s2_side;
      hue_lane[0] <= s2_hue;
      sat_lane[0] <= s2_sat;
    end
  end

  // Stages 3 to 6: divider, sideband carried alongside.
  for (genvar k = 0; k < 4; k++) begin : g_div
    hsr_div_stage u_div (
      .clk     (clk),
      .en      (en[3+k]),
      .hue_in  (hue_lane[k]),
      .sat_in  (sat_lane[k]),
      .hue_out (hue_lane[k+1]),
      .sat_out (sat_lane[k+1])
    );
    always_ff @(posedge clk) begin
      if (en[3+k]) side_r[3+k] <= side_r[2+k];
    end
  end

  // Stage 7: hue from its sector base, saturation and value.
  logic [14:0] s7_h_r;
  logic [15:0] s7_s_r, s7_v_r;
  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_h_r <= side_r[6].plus ? side_r[6].base + hue_lane[4].sh[14:0]
                               : side_r[6].base - hue_lane[4].sh[14:0];
      case (side_r[6].smode)
        SAT_ZERO: s7_s_r <= 16'd0;
        SAT_FULL: s7_s_r <= 16'hFFFF;
        default:  s7_s_r <= sat_lane[4].sh;
      endcase
      // floor(M * 65536 / 255) clipped to 65535 is M * 257.
      s7_v_r <= {side_r[6].mx, side_r[6].mx};
    end
  end

  // Stage 8: hue rotation with wrap, gains.
  logic [15:0] s8_hs;
  logic [14:0] s8_h;
  logic [31:0] s8_sp, s8_vp;
  logic [14:0] s8_h_r;
  logic [15:0] s8_s_r, s8_v_r;

  always_comb begin
    s8_hs = {1'b0, s7_h_r} + {1'b0, hue_offset_r};
    if (s8_hs >= HUE_TWO_TURNS)
      s8_h = 15'(s8_hs - HUE_TWO_TURNS);
    else if (s8_hs >= {1'b0, HUE_TURN})
      s8_h = 15'(s8_hs - {1'b0, HUE_TURN});
    else
      s8_h = s8_hs[14:0];
    s8_sp = {16'd0, s7_s_r} * {16'd0, sat_gain_r};
    s8_vp = {16'd0, s7_v_r} * {16'd0, val_gain_r};
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_h_r <= s8_h;
      s8_s_r <= s8_sp[31:16];
      s8_v_r <= s8_vp[31:16];
    end
  end

  // Stage 9: chroma, sector and position within the sector.
  logic [31:0] s9_cp;
  logic [2:0]  s9_sec;
  logic [14:0] s9_secbase;
  logic [15:0] s9_c_r, s9_v_r;
  logic [2:0]  s9_sec_r;
  logic [11:0] s9_f_r;

  always_comb begin
    s9_cp = {16'd0, s8_v_r} * {16'd0, s8_s_r};
    if (s8_h_r < HUE_SECTOR)                  s9_sec = 3'd0;
    else if (s8_h_r < 15'(2 * HUE_SECTOR))    s9_sec = 3'd1;
    else if (s8_h_r < 15'(3 * HUE_SECTOR))    s9_sec = 3'd2;
    else if (s8_h_r < 15'(4 * HUE_SECTOR))    s9_sec = 3'd3;
    else if (s8_h_r < 15'(5 * HUE_SECTOR))    s9_sec = 3'd4;
    else                                      s9_sec = 3'd5;
    s9_secbase = 15'(HUE_SECTOR * s9_sec);
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_c_r   <= s9_cp[31:16];
      s9_v_r   <= s8_v_r;
      s9_sec_r <= s9_sec;
      s9_f_r   <= 12'(s8_h_r - s9_secbase);
    end
  end

  // Stage 10: chroma times the rising or falling ramp, and the offset m.
  logic [11:0] s10_fm;
  logic [27:0] s10_p_r;
  logic [15:0] s10_c_r, s10_m_r;
  logic [2:0]  s10_sec_r;

  assign s10_fm = s9_sec_r[0] ? 12'(HUE_SECTOR - {3'd0, s9_f_r}) : s9_f_r;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_p_r   <= {12'd0, s9_c_r} * {16'd0, s10_fm};
      s10_c_r   <= s9_c_r;
      s10_m_r   <= s9_v_r - s9_c_r;
      s10_sec_r <= s9_sec_r;
    end
  end

  // Stage 11: divide by 3840 as a shift by eight, then a reciprocal of 15
  // that may fall short by up to two.
  logic [19:0] s11_y;
  logic [32:0] s11_qp;
  logic [19:0] s11_y_r;
  logic [16:0] s11_q_r;
  logic [15:0] s11_c_r, s11_m_r;
  logic [2:0]  s11_sec_r;

  assign s11_y  = s10_p_r[27:8];
  assign s11_qp = {13'd0, s11_y} * 33'd4369;

  always_ff @(posedge clk) begin
    if (en[11]) begin
      s11_y_r   <= s11_y;
      s11_q_r   <= s11_qp[32:16];
      s11_c_r   <= s10_c_r;
      s11_m_r   <= s10_m_r;
      s11_sec_r <= s10_sec_r;
    end
  end

  // Stage 12: correct the quotient.
  logic [19:0] s12_rem;
  logic [15:0] s12_x;
  logic [15:0] s12_x_r, s12_c_r, s12_m_r;
  logic [2:0]  s12_sec_r;

  always_comb begin
    s12_rem = s11_y_r - ({3'd0, s11_q_r} * 20'd15);
    if (s12_rem >= 20'd30)      s12_x = 16'(s11_q_r + 17'd2);
    else if (s12_rem >= 20'd15) s12_x = 16'(s11_q_r + 17'd1);
    else                        s12_x = s11_q_r[15:0];
  end

  always_ff @(posedge clk) begin
    if (en[12]) begin
      s12_x_r   <= s12_x;
      s12_c_r   <= s11_c_r;
      s12_m_r   <= s11_m_r;
      s12_sec_r <= s11_sec_r;
    end
  end

  // Stage 13: six-sector placement plus m.
  logic [15:0] s13_cr, s13_cg, s13_cb;
  logic [15:0] s13_r_r, s13_g_r, s13_b_r;

  always_comb begin
    case (s12_sec_r)
      3'd0: begin s13_cr = s12_c_r; s13_cg = s12_x_r; s13_cb = 16'd0;   end
      3'd1: begin s13_cr = s12_x_r; s13_cg = s12_c_r; s13_cb = 16'd0;   end
      3'd2: begin s13_cr = 16'd0;   s13_cg = s12_c_r; s13_cb = s12_x_r; end
      3'd3: begin s13_cr = 16'd0;   s13_cg = s12_x_r; s13_cb = s12_c_r; end
      3'd4: begin s13_cr = s12_x_r; s13_cg = 16'd0;   s13_cb = s12_c_r; end
      default: begin s13_cr = s12_c_r; s13_cg = 16'd0; s13_cb = s12_x_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[13]) begin
      s13_r_r <= s13_cr + s12_m_r;
      s13_g_r <= s13_cg + s12_m_r;
      s13_b_r <= s13_cb + s12_m_r;
    end
  end

  // Stage 14: Q0.16 to byte as (q * 255) >> 16; the sum never passes 65535,
  // so the result stays below 255 without a clip.
  logic [23:0] s14_r, s14_g, s14_b;
  out_pix_t    out_r;

  assign s14_r = {s13_r_r, 8'd0} - {8'd0, s13_r_r};
  assign s14_g = {s13_g_r, 8'd0} - {8'd0, s13_g_r};
  assign s14_b = {s13_b_r, 8'd0} - {8'd0, s13_b_r};

  always_ff @(posedge clk) begin
    if (en[14]) begin
      out_r.out_red   <= s14_r[23:16];
      out_r.out_green <= s14_g[23:16];
      out_r.out_blue  <= s14_b[23:16];
    end
  end

  assign out_data = out_r;
endmodule
`default_nettype wire

// File: tb/sv/tb_hsv_hue_shift_recolor_top.sv
// Testbench for the HSV hue shift recolor block: drives pixels, rotates the
// configuration over APB and checks every result word. Depends on hsr_pkg and hsv_hue_shift_recolor_top.
`default_nettype none
module tb_hsv_hue_shift_recolor_top;
  import hsr_pkg::*;

  // The cycle limit is generous: every word may wait a random gap on either
  // side, plus the pipeline depth and the register writes.
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_WAIT = 17;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_pix_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_pix_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // The shadow copy of the configuration that the predictor uses.
  logic [14:0] hue_offset_q;
  logic [15:0] sat_gain_q;
  logic [15:0] val_gain_q;

  out_pix_t    pixel_queue[$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          sink_busy = 1'b1;
  int          sink_wait = 0;
  int          sink_draw;

  hsv_hue_shift_recolor_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // A run that hangs ends here with the failure message.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [7:0] q16_to_byte(input logic [31:0] q);
    logic [31:0] t;
    t = (q * 32'd255) >> 16;
    return (t > 32'd255) ? 8'd255 : t[7:0];
  endfunction

  // Computes the recolored pixel with exact integer arithmetic, following
  // the same sector table as the hardware.
  function automatic out_pix_t recolor_pixel(input in_pix_t p);
    logic [31:0] r, g, b, mx, mn, d, h, s, v, c, m, x, sec, f, cr, cg, cb;
    out_pix_t o;
    r = 32'(p.in_red); g = 32'(p.in_green); b = 32'(p.in_blue);
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    // A grey pixel has no hue; red wins ties for the maximum, then green.
    if (d == 0) h = 0;
    else if (mx == r) h = (g >= b) ? (3840 * (g - b)) / d : 23040 - (3840 * (b - g)) / d;
    else if (mx == g) h = (b >= r) ? 7680 + (3840 * (b - r)) / d : 7680 - (3840 * (r - b)) / d;
    else h = (r >= g) ? 15360 + (3840 * (r - g)) / d : 15360 - (3840 * (g - r)) / d;
    if (mx == 0) s = 0;
    else begin
      s = (d << 16) / mx;
      if (s > 65535) s = 65535;
    end
    v = (mx << 16) / 255;
    if (v > 65535) v = 65535;
    h = (h + hue_offset_q) % 23040;
    s = (s * sat_gain_q) >> 16;
    v = (v * val_gain_q) >> 16;
    c = (v * s) >> 16;
    m = v - c;
    sec = h / 3840;
    f = h % 3840;
    x = sec[0] ? (c * (3840 - f)) / 3840 : (c * f) / 3840;
    case (sec)
      0: begin cr = c; cg = x; cb = 0; end
      1: begin cr = x; cg = c; cb = 0; end
      2: begin cr = 0; cg = c; cb = x; end
      3: begin cr = 0; cg = x; cb = c; end
      4: begin cr = x; cg = 0; cb = c; end
      default: begin cr = c; cg = 0; cb = x; end
    endcase
    o.out_red = q16_to_byte(cr + m);
    o.out_green = q16_to_byte(cg + m);
    o.out_blue = q16_to_byte(cb + m);
    return o;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("Mismatch in %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  // Sends one pixel after a random gap and waits until it is accepted.
  // Valid stays high after acceptance so that the next word can follow at
  // once; a gap or the drain drops it.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    in_pix_t p;
    int gap;
    p = '{r, g, b};
    gap = $urandom_range(3) == 0 ? 0 : $urandom_range(MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_queue.push_back(recolor_pixel(p));
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
  endtask

  // The receiver stalls for a random number of cycles after each word.
  always @(posedge clk) begin
    if (sink_busy) begin
      out_stall <= 1'b1;
      sink_wait <= 0;
    end else if (out_stall) begin
      if (sink_wait == 0) out_stall <= 1'b0;
      else sink_wait <= sink_wait - 1;
    end else if (out_valid) begin
      sink_draw = ($urandom_range(3) == 0) ? 0 : $urandom_range(MAX_WAIT);
      if (sink_draw > 0) begin
        out_stall <= 1'b1;
        sink_wait <= sink_draw - 1;
      end
    end
  end

  // Checks every accepted result word against the oldest expected pixel.
  always @(posedge clk) begin
    out_pix_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_queue.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = pixel_queue.pop_front();
        if (out_data.out_red !== want.out_red)
          report_mismatch("red", int'(out_data.out_red), int'(want.out_red));
        if (out_data.out_green !== want.out_green)
          report_mismatch("green", int'(out_data.out_green), int'(want.out_green));
        if (out_data.out_blue !== want.out_blue)
          report_mismatch("blue", int'(out_data.out_blue), int'(want.out_blue));
      end
    end
  end

  // Waits until every expected word has come back, then a little longer.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (NUM_STAGES + 4) @(posedge clk);
  endtask

  // The caller drops psel after the last access of a sequence.
  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (index)
      REG_HUE_OFFSET: hue_offset_q = value[14:0];
      REG_SAT_GAIN:   sat_gain_q = value[15:0];
      REG_VAL_GAIN:   val_gain_q = value[15:0];
      default: ;
    endcase
  endtask

  task automatic read_register(input logic [1:0] index, output logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {index, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
  endtask

  // Every register must read back what was last written to it.
  task automatic check_registers();
    logic [31:0] value;
    read_register(REG_HUE_OFFSET, value);
    if (value !== {17'd0, hue_offset_q})
      report_mismatch("hue_offset read", int'(value), int'(hue_offset_q));
    read_register(REG_SAT_GAIN, value);
    if (value !== {16'd0, sat_gain_q})
      report_mismatch("saturation_gain read", int'(value), int'(sat_gain_q));
    read_register(REG_VAL_GAIN, value);
    if (value !== {16'd0, val_gain_q})
      report_mismatch("value_gain read", int'(value), int'(val_gain_q));
  endtask

  task automatic set_config(input logic [31:0] hue, input logic [31:0] sg,
                            input logic [31:0] vg);
    drain_pipeline();
    write_register(REG_HUE_OFFSET, hue);
    write_register(REG_SAT_GAIN, sg);
    write_register(REG_VAL_GAIN, vg);
    check_registers();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_random_pixels(input int count);
    repeat (count) send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)));
  endtask

  // Extremes, greys, each hue sector and the ties for the maximum.
  task automatic test_directed_pixels();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd200, 8'd200, 8'd10);
    send_pixel(8'd10, 8'd200, 8'd200);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd170, 8'd85, 8'd85);
    send_pixel(8'd85, 8'd170, 8'd85);
    send_pixel(8'd85, 8'd85, 8'd170);
  endtask

  // Hue offsets at the edges of the turn and beyond it, gains at extremes.
  task automatic test_config_extremes();
    set_config(32'd23039, 32'd65535, 32'd65535);
    test_directed_pixels();
    set_config(32'd23040, 32'd0, 32'd65535);
    send_random_pixels(40);
    set_config(32'd32767, 32'd65535, 32'd0);
    send_random_pixels(40);
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_random_pixels(40);
  endtask

  task automatic test_random_settings();
    repeat (9) begin
      set_config($urandom, $urandom, $urandom);
      send_random_pixels(200);
    end
  endtask

  initial begin
    hue_offset_q = '0;
    sat_gain_q = 16'hFFFF;
    val_gain_q = 16'hFFFF;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sink_busy = 1'b0;
    // Reset values first, then the register extremes, then random settings.
    test_directed_pixels();
    test_config_extremes();
    test_random_settings();
    drain_pipeline();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
